FILE: sv/capsule_box_push_xz_macros.svh
// Assertion macros used by the checker.
`ifndef CAPSULE_BOX_PUSH_XZ_MACROS_SVH
`define CAPSULE_BOX_PUSH_XZ_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: sv/cbp_pkg.sv
// Package with shared types, constants and arithmetic helpers.
`default_nettype none
package cbp_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_SHIFT = 30;
    localparam int CFG_IDX_BITS = 3;
    localparam int IN_BITS = 208;
    localparam int OUT_BITS = 104;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CAP_A_X = 3'd0, REG_CAP_A_Y = 3'd1, REG_CAP_A_Z = 3'd2,
        REG_CAP_B_X = 3'd3, REG_CAP_B_Y = 3'd4, REG_CAP_B_Z = 3'd5,
        REG_CAP_RADIUS = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0] hx;
        logic [30:0] hy;
        logic [30:0] hz;
        logic [15:0] yaw;
    } box_t;

    typedef struct packed {
        logic gate;
        logic signed [33:0] dx;
        logic signed [33:0] dz;
        logic [30:0] hx;
        logic [30:0] hz;
        logic [30:0] r;
        logic [31:0] phase;
    } task_t;

    typedef struct packed {
        logic hit;
        logic signed [31:0] push_x;
        logic signed [31:0] push_z;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_z;
    } result_t;

    localparam int QW = $bits(task_t);

    function automatic logic signed [31:0] atan_turn(input int i);
        logic signed [31:0] t;
        begin
            unique case (i)
                0: t = 32'sd536870912;  1: t = 32'sd316933406;
                2: t = 32'sd167458908;  3: t = 32'sd85004756;
                4: t = 32'sd42667334;   5: t = 32'sd21354465;
                6: t = 32'sd10679838;   7: t = 32'sd5340245;
                8: t = 32'sd2670163;    9: t = 32'sd1335087;
                10: t = 32'sd667544;    11: t = 32'sd333772;
                12: t = 32'sd166886;    13: t = 32'sd83443;
                14: t = 32'sd41722;     15: t = 32'sd20861;
                16: t = 32'sd10430;     17: t = 32'sd5215;
                18: t = 32'sd2608;      19: t = 32'sd1304;
                20: t = 32'sd652;       21: t = 32'sd326;
                22: t = 32'sd163;       default: t = 32'sd81;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/cbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/cbp_front.sv
// Front end: vertical gate, capsule midpoint offset and phase for each box beat.
`default_nettype none
module cbp_front
    import cbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire box_t        in_box,
    output logic             out_valid,
    input  wire logic        out_ready,
    output task_t            out_task
);
    logic signed [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [30:0] r_reg;
    logic valid_reg;
    task_t task_reg;
    task_t task_next;
    logic signed [33:0] lo_y, hi_y, blo, bhi, sx, sz;
    logic signed [31:0] ymin, ymax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
            r_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CAP_A_X:    ax_reg <= cfg_data;
                REG_CAP_A_Y:    ay_reg <= cfg_data;
                REG_CAP_A_Z:    az_reg <= cfg_data;
                REG_CAP_B_X:    bx_reg <= cfg_data;
                REG_CAP_B_Y:    by_reg <= cfg_data;
                REG_CAP_B_Z:    bz_reg <= cfg_data;
                REG_CAP_RADIUS: r_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ymin = (ay_reg < by_reg) ? ay_reg : by_reg;
        ymax = (ay_reg > by_reg) ? ay_reg : by_reg;
        lo_y = 34'(ymin) - 34'(signed'({1'b0, r_reg}));
        hi_y = 34'(ymax) + 34'(signed'({1'b0, r_reg}));
        blo = 34'(in_box.cy) - 34'(signed'({1'b0, in_box.hy}));
        bhi = 34'(in_box.cy) + 34'(signed'({1'b0, in_box.hy}));
        sx = 34'(ax_reg) + 34'(bx_reg);
        sz = 34'(az_reg) + 34'(bz_reg);
        task_next.gate = !(hi_y < blo || lo_y > bhi);
        task_next.dx = (sx >>> 1) - 34'(in_box.cx);
        task_next.dz = (sz >>> 1) - 34'(in_box.cz);
        task_next.hx = in_box.hx;
        task_next.hz = in_box.hz;
        task_next.r = r_reg;
        task_next.phase = {in_box.yaw[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_task = task_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            task_reg <= task_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/cbp_queue.sv
// Short FIFO between front and back ends, built on the generic RAM.
`default_nettype none
module cbp_queue
    import cbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire task_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output task_t      out_data
);
    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic [QW-1:0] rdata;
    logic push, pop_ram, deq;

    // The output stage is a two-entry buffer fed from RAM in the cycle after a
    // read. A read is issued only when its data is sure to find a free entry,
    // so a beat can leave every cycle.
    logic rd_pend_reg;
    logic [1:0] ocnt_reg, ocnt_next;
    task_t h0_reg, h1_reg, h0_next, h1_next;
    logic [2:0] occ;
    logic [AW:0] avail;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push = in_valid && in_ready;
    assign deq = out_ready && (ocnt_reg != 2'd0);
    assign occ = 3'(ocnt_reg) + 3'(rd_pend_reg) - 3'(deq);
    assign avail = cnt_reg;
    assign pop_ram = (occ <= 3'd1) && (avail != '0);
    assign ocnt_next = 2'(occ);

    cbp_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(push), .waddr(wp_reg), .wdata(in_data),
        .raddr(rp_reg), .rdata(rdata)
    );

    always_comb
    begin
        h0_next = h0_reg;
        h1_next = h1_reg;
        if (deq)
        begin
            h0_next = h1_reg;
        end
        if (rd_pend_reg)
        begin
            if ((ocnt_reg - 2'(deq)) == 2'd0)
            begin
                h0_next = task_t'(rdata);
            end
            else
            begin
                h1_next = task_t'(rdata);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
            rd_pend_reg <= 1'b0; ocnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop_ram)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop_ram);
            rd_pend_reg <= pop_ram;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

    assign out_valid = (ocnt_reg != 2'd0);
    assign out_data = h0_reg;
endmodule
`default_nettype wire

FILE: sv/cbp_back.sv
// Back end pipeline: CORDIC, rotations, clamp, square root, divisions and rotation back.
`default_nettype none
module cbp_back
    import cbp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire task_t   in_task,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);
    // Stages: 0..23 CORDIC, fold, rotate, clamp, d2, 32 sqrt steps, 48 div steps, back.
    localparam int SQ = 32;
    localparam int DV = 48;
    localparam int NS = CORDIC_STEPS + 4 + SQ + DV + 4;

    typedef struct packed {
        logic gate;
        logic signed [33:0] dx, dz;
        logic [30:0] hx, hz, r;
        logic [1:0] q;
        logic signed [33:0] x, y, z;
        logic signed [33:0] c, s;
        logic signed [33:0] lx, lz;
        logic signed [34:0] vx, vz;
        logic [63:0] d2;
        logic mode_in, outside_hit;
        logic signed [34:0] ipx, ipz;
        logic signed [17:0] inx, inz;
        logic [63:0] sv, sres;
        logic [31:0] d;
        logic [31:0] pen;
        logic [1:0] dvsel;
        logic [95:0] rx, rz, nx, nz;
        logic [63:0] qx, qz, qnx, qnz;
    } st_t;

    st_t st [NS];
    logic vld [NS];
    logic adv;

    assign adv = !vld[NS-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld[NS-1];

    function automatic st_t cordic_step(input st_t a, input int i);
        st_t b;
        logic signed [33:0] xs, ys;
        begin
            b = a;
            xs = a.x >>> i;
            ys = a.y >>> i;
            if (!a.z[33])
            begin
                b.x = a.x - ys; b.y = a.y + xs; b.z = a.z - 34'(atan_turn(i));
            end
            else
            begin
                b.x = a.x + ys; b.y = a.y - xs; b.z = a.z + 34'(atan_turn(i));
            end
            return b;
        end
    endfunction

    function automatic logic signed [35:0] rrnd(input logic signed [69:0] v);
        logic signed [69:0] t;
        begin
            t = v + 70'sd536870912;
            return 36'(t >>> TRIG_SHIFT);
        end
    endfunction

    // One bit of a restoring unsigned division of a 96-bit remainder by d.
    function automatic void div_bit(inout logic [95:0] rem, inout logic [63:0] q,
                                    input logic [31:0] d, input int b);
        logic [95:0] t;
        begin
            t = {64'd0, d} << b;
            if (rem >= t)
            begin
                rem = rem - t;
                q[b] = 1'b1;
            end
        end
    endfunction

    st_t s0;
    always_comb
    begin
        logic [31:0] ph;
        logic [1:0] qq;
        logic [31:0] rem;
        s0 = '0;
        ph = in_task.phase;
        qq = 2'((ph + 32'h2000_0000) >> 30);
        rem = ph - {qq, 30'd0};
        s0.gate = in_task.gate;
        s0.dx = in_task.dx; s0.dz = in_task.dz;
        s0.hx = in_task.hx; s0.hz = in_task.hz; s0.r = in_task.r;
        s0.q = qq;
        s0.x = 34'sd652032874;
        s0.y = '0;
        s0.z = 34'(signed'(rem));
    end

    // Per-stage next values.
    st_t nxt [NS];
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            st_t a, b;
            a = (k == 0) ? s0 : st[k-1];
            b = a;
            if (k < CORDIC_STEPS)
            begin
                b = cordic_step(a, k);
            end
            else if (k == CORDIC_STEPS)
            begin
                unique case (a.q)
                    2'd0: begin b.c = a.x;  b.s = a.y;  end
                    2'd1: begin b.c = -a.y; b.s = a.x;  end
                    2'd2: begin b.c = -a.x; b.s = -a.y; end
                    default: begin b.c = a.y; b.s = -a.x; end
                endcase
            end
            else if (k == CORDIC_STEPS + 1)
            begin
                b.lx = 34'(rrnd(70'(a.c) * 70'(a.dx) + 70'(a.s) * 70'(a.dz)));
                b.lz = 34'(rrnd(70'(a.c) * 70'(a.dz) - 70'(a.s) * 70'(a.dx)));
            end
            else if (k == CORDIC_STEPS + 2)
            begin
                logic signed [34:0] hx, hz, clx, clz;
                hx = 35'(a.hx); hz = 35'(a.hz);
                clx = (35'(a.lx) < -hx) ? -hx : ((35'(a.lx) > hx) ? hx : 35'(a.lx));
                clz = (35'(a.lz) < -hz) ? -hz : ((35'(a.lz) > hz) ? hz : 35'(a.lz));
                b.vx = 35'(a.lx) - clx;
                b.vz = 35'(a.lz) - clz;
                b.mode_in = (b.vx == 0) && (b.vz == 0);
            end
            else if (k == CORDIC_STEPS + 3)
            begin
                logic [34:0] ax, az, alx, alz;
                logic signed [34:0] px, pz, rr;
                logic signed [17:0] one;
                one = 18'sd65536;
                ax = a.vx[34] ? 35'(-a.vx) : 35'(a.vx);
                az = a.vz[34] ? 35'(-a.vz) : 35'(a.vz);
                b.d2 = 64'(ax) * 64'(ax) + 64'(az) * 64'(az);
                b.outside_hit = !a.mode_in && (ax < 35'(a.r)) && (az < 35'(a.r)) &&
                                (b.d2 < 64'(a.r) * 64'(a.r));
                alx = a.lx[33] ? 35'(-a.lx) : 35'(a.lx);
                alz = a.lz[33] ? 35'(-a.lz) : 35'(a.lz);
                px = 35'(a.hx) - signed'(alx);
                pz = 35'(a.hz) - signed'(alz);
                rr = 35'(a.r);
                if (px < pz)
                begin
                    b.inx = a.lx[33] ? -one : one; b.inz = '0;
                    b.ipx = a.lx[33] ? -(px + rr) : (px + rr); b.ipz = '0;
                end
                else
                begin
                    b.inx = '0; b.inz = a.lz[33] ? -one : one;
                    b.ipx = '0; b.ipz = a.lz[33] ? -(pz + rr) : (pz + rr);
                end
                b.sv = b.d2; b.sres = '0;
            end
            else if (k < CORDIC_STEPS + 4 + SQ)
            begin
                int j;
                logic [63:0] bit_v;
                j = k - (CORDIC_STEPS + 4);
                bit_v = 64'd1 << (62 - 2 * j);
                if (a.sv >= a.sres + bit_v)
                begin
                    b.sv = a.sv - (a.sres + bit_v);
                    b.sres = (a.sres >> 1) + bit_v;
                end
                else
                begin
                    b.sres = a.sres >> 1;
                end
                if (k == CORDIC_STEPS + 3 + SQ)
                begin
                    logic [34:0] ax, az;
                    b.d = b.sres[31:0];
                    b.pen = 32'(a.r) - b.sres[31:0];
                    ax = a.vx[34] ? 35'(-a.vx) : 35'(a.vx);
                    az = a.vz[34] ? 35'(-a.vz) : 35'(a.vz);
                    b.nx = 96'(ax) * 96'd65536 + 96'(b.sres[31:1]);
                    b.nz = 96'(az) * 96'd65536 + 96'(b.sres[31:1]);
                    b.rx = 96'(64'(ax) * 64'(b.pen)) + 96'(b.sres[31:1]);
                    b.rz = 96'(64'(az) * 64'(b.pen)) + 96'(b.sres[31:1]);
                    b.qx = '0; b.qz = '0; b.qnx = '0; b.qnz = '0;
                end
            end
            else if (k < CORDIC_STEPS + 4 + SQ + DV)
            begin
                int j;
                j = (DV - 1) - (k - (CORDIC_STEPS + 4 + SQ));
                if (a.d != '0)
                begin
                    div_bit(b.rx, b.qx, a.d, j);
                    div_bit(b.rz, b.qz, a.d, j);
                    div_bit(b.nx, b.qnx, a.d, j);
                    div_bit(b.nz, b.qnz, a.d, j);
                end
            end
            else if (k == CORDIC_STEPS + 4 + SQ + DV)
            begin
                logic signed [63:0] t;
                if (!a.mode_in)
                begin
                    t = a.vx[34] ? -signed'(a.qnx) : signed'(a.qnx);
                    b.inx = (t > 64'sd65536) ? 18'sd65536 :
                            ((t < -64'sd65536) ? -18'sd65536 : 18'(t));
                    t = a.vz[34] ? -signed'(a.qnz) : signed'(a.qnz);
                    b.inz = (t > 64'sd65536) ? 18'sd65536 :
                            ((t < -64'sd65536) ? -18'sd65536 : 18'(t));
                    b.ipx = 35'(a.vx[34] ? -signed'(a.qx) : signed'(a.qx));
                    b.ipz = 35'(a.vz[34] ? -signed'(a.qz) : signed'(a.qz));
                end
            end
            else if (k == CORDIC_STEPS + 5 + SQ + DV)
            begin
                b.rx = 96'(70'(a.c) * 70'(a.ipx));
                b.rz = 96'(70'(a.s) * 70'(a.ipz));
                b.nx = 96'(70'(a.s) * 70'(a.ipx));
                b.nz = 96'(70'(a.c) * 70'(a.ipz));
            end
            else if (k == CORDIC_STEPS + 6 + SQ + DV)
            begin
                b.qx = 64'(rrnd(70'(a.rx) - 70'(a.rz)));
                b.qz = 64'(rrnd(70'(a.nx) + 70'(a.nz)));
                b.sv = 64'(rrnd(70'(a.c) * 70'(a.inx) - 70'(a.s) * 70'(a.inz)));
                b.sres = 64'(rrnd(70'(a.s) * 70'(a.inx) + 70'(a.c) * 70'(a.inz)));
            end
            nxt[k] = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                vld[k] <= vld[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++)
            begin
                st[k] <= nxt[k];
            end
        end
    end

    always_comb
    begin
        st_t f;
        logic signed [63:0] px, pz, nx, nz;
        logic h;
        f = st[NS-1];
        px = signed'(f.qx); pz = signed'(f.qz);
        nx = signed'(f.sv); nz = signed'(f.sres);
        h = f.gate && (f.mode_in || f.outside_hit);
        out_res.hit = h;
        out_res.push_x = !h ? '0 : (px > 64'sd2147483647) ? 32'h7fffffff :
                         (px < -64'sd2147483648) ? 32'h80000000 : 32'(px);
        out_res.push_z = !h ? '0 : (pz > 64'sd2147483647) ? 32'h7fffffff :
                         (pz < -64'sd2147483648) ? 32'h80000000 : 32'(pz);
        out_res.normal_x = !h ? '0 : (nx > 64'sd65536) ? 18'sd65536 :
                           (nx < -64'sd65536) ? -18'sd65536 : 18'(nx);
        out_res.normal_z = !h ? '0 : (nz > 64'sd65536) ? 18'sd65536 :
                           (nz < -64'sd65536) ? -18'sd65536 : 18'(nz);
    end
endmodule
`default_nettype wire

FILE: sv/capsule_box_push_xz.sv
// Top level of the capsule against oriented box push unit.
// Usage:
//   Configure the capsule through cfg_we/cfg_idx/cfg_data while idle
//   (index 0..5 endpoints A and B, index 6 radius; other indexes ignored).
//   Box beats enter on s_axis (tdata fields below), one result beat per box
//   leaves on m_axis in order.
// Throughput: one box per cycle when m_axis_tready stays high.
// Path: a box passes the front register, the queue (RAM and output buffer) and
//   112 back-end stages (24-step CORDIC, 32-step square root, 48-step divider)
//   before its result can be taken.
// Reset clears the capsule registers to zero and empties every stage.
// When the receiver stalls, the back-end pipeline holds, the queue between
//   front and back fills, and s_axis_tready falls once front and queue are full.
`default_nettype none
module capsule_box_push_xz
    import cbp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_idx,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // cx, cy, cz (32 each), hx, hy, hz (31 each), yaw (16), pad
    input  wire logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // hit (1), push_x (32), push_z (32), normal_x (18), normal_z (18), pad
    output logic [OUT_BITS-1:0]      m_axis_tdata
);
    box_t box;
    task_t f_task, q_task;
    logic f_valid, f_ready, q_valid, q_ready;
    result_t res;

    assign box.cx = s_axis_tdata[31:0];
    assign box.cy = s_axis_tdata[63:32];
    assign box.cz = s_axis_tdata[95:64];
    assign box.hx = s_axis_tdata[126:96];
    assign box.hy = s_axis_tdata[157:127];
    assign box.hz = s_axis_tdata[188:158];
    assign box.yaw = s_axis_tdata[204:189];

    cbp_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_box(box), .out_valid(f_valid), .out_ready(f_ready), .out_task(f_task)
    );

    cbp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready),
        .in_data(f_task), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_task)
    );

    cbp_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_ready(q_ready),
        .in_task(q_task), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_res(res)
    );

    assign m_axis_tdata = {3'd0, res.normal_z, res.normal_x, res.push_z,
                           res.push_x, res.hit};
endmodule
`default_nettype wire

FILE: sv/cbp_checker.sv
// Port-level checker for the top level, attached by bind.
`default_nettype none
`include "capsule_box_push_xz_macros.svh"
module cbp_checker
    import cbp_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_BITS-1:0] m_axis_tdata
);
    `CBP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `CBP_ASSERT_IMP(a_miss_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[100:1] == '0)
    `CBP_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[103:101] == '0)
    `CBP_ASSERT_IMP(a_ready_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tready))
endmodule
bind capsule_box_push_xz cbp_checker u_cbp_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the capsule against oriented box push unit.
`default_nettype none
module testbench;
    import cbp_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 150;
    localparam longint ONE = 64'sd1 <<< FRAC_BITS;
    localparam longint Q1 = 64'sd65536;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_idx = '0;
    logic [31:0]         cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    // Capsule registers as the block should hold them.
    longint cap_ax, cap_ay, cap_az, cap_bx, cap_by, cap_bz, cap_r;

    typedef struct {
        box_t    b;
        bit      typed;
        result_t want;
    } dir_row_t;

    result_t  pending_push_q[$];
    dir_row_t dir_tab[$];
    int       boxes_sent = 0;
    int       err_cnt = 0;
    int       cyc = 0;
    int       stall_left = 0;
    bit       long_hold_done = 1'b0;
    int       rdy_roll;

    longint atan_tab[CORDIC_STEPS] = '{
        536870912, 316933406, 167458908, 85004756, 42667334, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    capsule_box_push_xz dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint trig_round(input longint v);
        return (v + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    endfunction

    function automatic longint div_half_up(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? -num : num;
        q = (mag + longint'(den) / 2) / longint'(den);
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    // Quadrant-folded CORDIC on a 32-bit turn phase, Q2.30 results.
    task automatic yaw_sincos(input logic [31:0] phase, output longint c, output longint s);
        logic [31:0] q;
        logic [31:0] rem;
        longint x, y, z, xs, ys;
        q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
        rem = phase - (q << 30);
        z = longint'({32'd0, rem});
        x = 652032874;
        y = 0;
        if (z >= 64'sh8000_0000)
            z = z - 64'sh1_0000_0000;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic capsule_push_predict(input box_t b, output result_t res);
        longint ccx, ccy, ccz, hx, hy, hz, lo_y, hi_y;
        longint c, s, dx, dz, lx, lz, vx, vz, ax, az, d, pen, px, pz;
        longint plx, plz, nlx, nlz;
        longint unsigned d2;
        logic [31:0] phase;
        bit hit;
        ccx = longint'(b.cx); ccy = longint'(b.cy); ccz = longint'(b.cz);
        hx = longint'({33'd0, b.hx}); hy = longint'({33'd0, b.hy});
        hz = longint'({33'd0, b.hz});
        phase = {b.yaw, 16'd0};
        lo_y = (cap_ay < cap_by ? cap_ay : cap_by) - cap_r;
        hi_y = (cap_ay > cap_by ? cap_ay : cap_by) + cap_r;
        hit = 1'b0;
        plx = 0; plz = 0; nlx = 0; nlz = 0;
        res = '0;
        if (!(hi_y < ccy - hy || lo_y > ccy + hy))
        begin
            dx = ((cap_ax + cap_bx) >>> 1) - ccx;
            dz = ((cap_az + cap_bz) >>> 1) - ccz;
            yaw_sincos(phase, c, s);
            lx = trig_round(c * dx + s * dz);
            lz = trig_round(c * dz - s * dx);
            vx = lx - clip(lx, -hx, hx);
            vz = lz - clip(lz, -hz, hz);
            if (vx != 0 || vz != 0)
            begin
                ax = vx < 0 ? -vx : vx;
                az = vz < 0 ? -vz : vz;
                if (ax < cap_r && az < cap_r)
                begin
                    d2 = longint'(ax * ax) + longint'(az * az);
                    if (d2 < longint'(cap_r * cap_r))
                    begin
                        d = floor_sqrt(d2);
                        pen = cap_r - d;
                        nlx = clip(div_half_up(vx * ONE, d), -ONE, ONE);
                        nlz = clip(div_half_up(vz * ONE, d), -ONE, ONE);
                        plx = div_half_up(vx * pen, d);
                        plz = div_half_up(vz * pen, d);
                        hit = 1'b1;
                    end
                end
            end
            else
            begin
                // Inside the rectangle: leave through the nearer face pair, ties along Z.
                px = hx - (lx < 0 ? -lx : lx);
                pz = hz - (lz < 0 ? -lz : lz);
                if (px < pz)
                begin
                    nlx = lx >= 0 ? ONE : -ONE;
                    plx = lx >= 0 ? px + cap_r : -(px + cap_r);
                end
                else
                begin
                    nlz = lz >= 0 ? ONE : -ONE;
                    plz = lz >= 0 ? pz + cap_r : -(pz + cap_r);
                end
                hit = 1'b1;
            end
            if (hit)
            begin
                res.hit = 1'b1;
                res.push_x = 32'(clip(trig_round(c * plx - s * plz), -64'sh8000_0000,
                                      64'sh7FFF_FFFF));
                res.push_z = 32'(clip(trig_round(s * plx + c * plz), -64'sh8000_0000,
                                      64'sh7FFF_FFFF));
                res.normal_x = 18'(clip(trig_round(c * nlx - s * nlz), -ONE, ONE));
                res.normal_z = 18'(clip(trig_round(s * nlx + c * nlz), -ONE, ONE));
            end
        end
    endtask

    function automatic result_t unpack_result(input logic [OUT_BITS-1:0] d);
        result_t r;
        r.hit = d[0];
        r.push_x = d[32:1];
        r.push_z = d[64:33];
        r.normal_x = d[82:65];
        r.normal_z = d[100:83];
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            if (pending_push_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_push_q.pop_front();
                if (got.hit !== want.hit || got.push_x !== want.push_x ||
                    got.push_z !== want.push_z || got.normal_x !== want.normal_x ||
                    got.normal_z !== want.normal_z)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Receiver: one long hold-off while the sender keeps going, a calm
    // stretch, and short random stalls elsewhere.
    always @(posedge clk)
    begin
        if (!long_hold_done && boxes_sent >= 200)
        begin
            long_hold_done <= 1'b1;
            stall_left <= 700;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (boxes_sent >= 320 && boxes_sent < 400)
            m_axis_tready <= 1'b1;
        else
        begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 2)
                stall_left <= $urandom_range(10, 60);
            m_axis_tready <= (rdy_roll >= 20);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_box(input box_t b);
        int roll;
        int gap;
        result_t r;
        roll = $urandom_range(0, 99);
        gap = roll < 60 ? 0 : (roll < 90 ? $urandom_range(1, 3) : $urandom_range(5, 30));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_BITS-205){1'b0}}, b.yaw, b.hz, b.hy, b.hx, b.cz, b.cy, b.cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        capsule_push_predict(b, r);
        pending_push_q.push_back(r);
        boxes_sent++;
    endtask

    // Sender pauses until every result is back, then waits out the pipeline.
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (pending_push_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAP_A_X:    cap_ax = longint'(signed'(val));
            REG_CAP_A_Y:    cap_ay = longint'(signed'(val));
            REG_CAP_A_Z:    cap_az = longint'(signed'(val));
            REG_CAP_B_X:    cap_bx = longint'(signed'(val));
            REG_CAP_B_Y:    cap_by = longint'(signed'(val));
            REG_CAP_B_Z:    cap_bz = longint'(signed'(val));
            REG_CAP_RADIUS: cap_r = longint'({33'd0, val[30:0]});
            default: ;
        endcase
    endtask

    task automatic load_capsule(input longint ax, ay, az, bx, by, bz, r);
        write_reg(REG_CAP_A_X, ax[31:0]);
        write_reg(REG_CAP_A_Y, ay[31:0]);
        write_reg(REG_CAP_A_Z, az[31:0]);
        write_reg(REG_CAP_B_X, bx[31:0]);
        write_reg(REG_CAP_B_Y, by[31:0]);
        write_reg(REG_CAP_B_Z, bz[31:0]);
        write_reg(REG_CAP_RADIUS, r[31:0]);
    endtask

    function automatic box_t make_box(input longint cx, cy, cz, hx, hy, hz,
                                      input int yaw);
        box_t b;
        b.cx = cx[31:0]; b.cy = cy[31:0]; b.cz = cz[31:0];
        b.hx = hx[30:0]; b.hy = hy[30:0]; b.hz = hz[30:0];
        b.yaw = yaw[15:0];
        return b;
    endfunction

    task automatic add_row(input box_t b, input bit typed);
        dir_row_t row;
        row.b = b;
        row.typed = typed;
        row.want = '0;
        dir_tab.push_back(row);
    endtask

    // Box near the capsule midpoint so most of them reach the XZ test.
    function automatic box_t near_box(input longint spread, input longint half_max);
        longint mx, my, mz;
        mx = (cap_ax + cap_bx) >>> 1;
        my = (cap_ay + cap_by) >>> 1;
        mz = (cap_az + cap_bz) >>> 1;
        return make_box(
            clip(mx + $signed($urandom_range(0, 32'(2 * spread))) - spread,
                 -64'sh8000_0000, 64'sh7FFF_FFFF),
            clip(my + $signed($urandom_range(0, 32'(2 * spread))) - spread,
                 -64'sh8000_0000, 64'sh7FFF_FFFF),
            clip(mz + $signed($urandom_range(0, 32'(2 * spread))) - spread,
                 -64'sh8000_0000, 64'sh7FFF_FFFF),
            $urandom_range(0, 32'(half_max)), $urandom_range(0, 32'(half_max)),
            $urandom_range(0, 32'(half_max)), $urandom_range(0, 65535));
    endfunction

    function automatic box_t noise_box();
        return make_box(longint'(signed'($urandom())), longint'(signed'($urandom())),
                        longint'(signed'($urandom())), $urandom() >> 1, $urandom() >> 1,
                        $urandom() >> 1, $urandom_range(0, 65535));
    endfunction

    task automatic random_phase(input int count, input longint spread,
                                input longint half_max);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                send_box(near_box(spread, half_max));
            else
                send_box(noise_box());
        end
        drain_all();
    endtask

    initial
    begin
        result_t r;
        cap_ax = 0; cap_ay = 0; cap_az = 0; cap_bx = 0; cap_by = 0; cap_bz = 0; cap_r = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: zero radius, a centre inside the box still hits.
        add_row(make_box(0, 0, 0, Q1, Q1, Q1, 0), 1'b0);
        add_row(make_box(0, 0, 0, 0, 0, 0, 0), 1'b0);
        add_row(make_box(5 * Q1, 0, 0, Q1, Q1, Q1, 0), 1'b1);
        foreach (dir_tab[i])
            send_box(dir_tab[i].b);
        drain_all();
        dir_tab.delete();

        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        load_capsule(0, 0, 0, 0, 2 * Q1, 0, Q1 / 2);
        // Vertical miss above and below.
        add_row(make_box(0, 100 * Q1, 0, Q1, Q1, Q1, 0), 1'b1);
        add_row(make_box(0, -100 * Q1, 0, Q1, Q1, Q1, 16384), 1'b1);
        // Outside, component beyond the radius, and outside with d2 past r^2.
        add_row(make_box(10 * Q1, Q1, 0, Q1, Q1, Q1, 0), 1'b1);
        add_row(make_box(Q1 + 2 * Q1 / 5, Q1, Q1 + 2 * Q1 / 5, Q1, Q1, Q1, 0), 1'b0);
        // Outside and touching, at several yaws.
        add_row(make_box(Q1 + Q1 / 4, Q1, 0, Q1, Q1, Q1, 0), 1'b0);
        add_row(make_box(Q1 + Q1 / 4, Q1, 0, Q1, Q1, Q1, 8192), 1'b0);
        add_row(make_box(0, Q1, -Q1 - Q1 / 8, Q1, Q1, Q1, 32768), 1'b0);
        // Inside: tie, nearer X face, nearer Z face, negative and zero coordinates.
        add_row(make_box(0, Q1, 0, Q1, Q1, Q1, 0), 1'b0);
        add_row(make_box(Q1 / 2, Q1, 0, Q1, Q1, 2 * Q1, 0), 1'b0);
        add_row(make_box(-Q1 / 2, Q1, 0, Q1, Q1, 2 * Q1, 49152), 1'b0);
        add_row(make_box(0, Q1, Q1 / 3, 3 * Q1, Q1, Q1, 65535), 1'b0);
        add_row(make_box(0, Q1, -Q1 / 3, 3 * Q1, Q1, Q1, 16384), 1'b0);
        // Field extremes.
        add_row(make_box(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                         64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 65535), 1'b0);
        add_row(make_box(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                         64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0), 1'b0);
        add_row(make_box(-64'sh8000_0000, 0, 64'sh7FFF_FFFF, 0, 64'sh7FFF_FFFF, 0,
                         32768), 1'b0);
        add_row(make_box(0, 0, 0, 0, 0, 0, 0), 1'b0);
        foreach (dir_tab[i])
            send_box(dir_tab[i].b);
        foreach (dir_tab[i])
            if (dir_tab[i].typed)
            begin
                // Typed rows are all no-hit; the predictor must agree.
                capsule_push_predict(dir_tab[i].b, r);
                if (r !== dir_tab[i].want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("typed row %0d disagrees: expected %p, got %p", i,
                                 dir_tab[i].want, r);
                end
            end
        drain_all();

        // Random phases across several capsule settings.
        random_phase(140, 4 * Q1, 3 * Q1);
        load_capsule(-7 * Q1, -Q1, 3 * Q1, -5 * Q1, 4 * Q1, 2 * Q1, 3 * Q1);
        random_phase(130, 8 * Q1, 4 * Q1);
        load_capsule(Q1, 0, -Q1, Q1 + 5, 0, -Q1 + 3, 0);
        random_phase(80, 2 * Q1, 2 * Q1);
        load_capsule(64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000,
                     64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF);
        random_phase(100, 64'sh3FFF_FFFF, 64'sh7FFF_FFFF);
        load_capsule(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                     64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000, Q1 / 16);
        random_phase(60, Q1, Q1);
        load_capsule(longint'(signed'($urandom())) >>> 8, 0, longint'(signed'($urandom())) >>> 8,
                     longint'(signed'($urandom())) >>> 8, Q1, longint'(signed'($urandom())) >>> 8,
                     $urandom_range(32'(Q1 / 4), 32'(4 * Q1)));
        random_phase(100, 6 * Q1, 3 * Q1);

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/cbp_pkg.sv
sv/cbp_ram.sv
sv/cbp_front.sv
sv/cbp_queue.sv
sv/cbp_back.sv
sv/capsule_box_push_xz.sv
sv/cbp_checker.sv
tb/testbench.sv
